>>> hdl/gf2i_pkg.sv
// shared types and constants of the gf(2^m) inverter
package gf2i_pkg;

    // widest supported field plus the top bit of the reduction polynomial
    localparam int MAX_POLY_BITS = 33;

    // reset polynomial x^10 + x^3 + 1
    localparam logic [MAX_POLY_BITS-1:0] DEFAULT_POLY = 33'h0_0000_0409;

    // status of the euclid engine towards the output stage
    typedef struct packed {
        logic idle;
        logic done;
        logic zero_op;
    } core_stat_t;

endpackage

>>> hdl/gf2i_cfg.sv
// apb register holding the reduction polynomial
module gf2i_cfg #(
    parameter int FIELD_BITS = 10,
    parameter int DATA_W     = 32,
    parameter int ADDR_W     = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic [FIELD_BITS:0] poly
);

    logic [FIELD_BITS:0] poly_reg;
    logic                hit;

    // the register answers at every word whose top address bit is clear
    assign hit = (paddr[ADDR_W-1] == 1'b0);

    // polynomial register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= gf2i_pkg::DEFAULT_POLY[FIELD_BITS:0];
        end
        else if (psel && penable && pwrite && hit)
        begin
            poly_reg <= pwdata[FIELD_BITS:0];
        end
    end

    // readback
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[FIELD_BITS:0] = poly_reg;
        end
    end

    assign poly = poly_reg;

endmodule

>>> hdl/gf2i_core.sv
// bit-serial extended euclid engine over left-aligned binary polynomials
module gf2i_core #(
    parameter int FIELD_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FIELD_BITS-1:0]   operand,
    input  logic [FIELD_BITS:0]     poly,
    input  logic                    ack,
    output gf2i_pkg::core_stat_t    stat,
    output logic [FIELD_BITS-1:0]   result
);

    localparam int N  = FIELD_BITS;
    localparam int DW = $clog2(FIELD_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    // w: working remainder, r0/r1: dividend and divisor, all top-aligned at bit n
    logic [N:0]    w_reg, w_next;
    logic [N:0]    r0_reg, r0_next;
    logic [N:0]    r1_reg, r1_next;
    // bezout coefficients, kept reduced
    logic [N-1:0]  t0_reg, t0_next;
    logic [N-1:0]  t1_reg, t1_next;
    logic [N-1:0]  acc_reg, acc_next;
    logic [N-1:0]  res_reg, res_next;
    logic          zero_reg, zero_next;
    logic [DW-1:0] d0_reg, d0_next;
    logic [DW-1:0] d1_reg, d1_next;
    logic [DW-1:0] cur_reg, cur_next;
    logic [DW-1:0] sh_reg, sh_next;

    logic [N:0]    m_poly;
    logic [N-1:0]  acc_x;
    logic [N-1:0]  acc_step;
    logic [N:0]    w_sub;
    logic          q_bit;

    // top bit of the modulus is always set
    assign m_poly = {1'b1, poly[N-1:0]};

    // one quotient bit per cycle: eliminate leading term, horner step on q*t1
    assign q_bit    = w_reg[N];
    assign w_sub    = w_reg ^ (q_bit ? r1_reg : '0);
    assign acc_x    = {acc_reg[N-2:0], 1'b0} ^ (acc_reg[N-1] ? m_poly[N-1:0] : '0);
    assign acc_step = acc_x ^ (q_bit ? t1_reg : '0);

    // sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        zero_next  = zero_reg;
        d0_next    = d0_reg;
        d1_next    = d1_reg;
        cur_next   = cur_reg;
        sh_next    = sh_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operand == '0)
                    begin
                        res_next   = '0;
                        zero_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        r0_next    = m_poly;
                        d0_next    = DW'(N);
                        t0_next    = '0;
                        t1_next    = {{(N-1){1'b0}}, 1'b1};
                        w_next     = {1'b0, operand};
                        cur_next   = DW'(N);
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                // shift the new remainder up until its leading term sits at bit n
                if (w_reg[N])
                begin
                    r1_next = w_reg;
                    d1_next = cur_reg;
                    if (cur_reg == '0)
                    begin
                        res_next   = t1_reg;
                        zero_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        w_next     = r0_reg;
                        sh_next    = d0_reg - cur_reg;
                        acc_next   = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    w_next   = {w_reg[N-1:0], 1'b0};
                    cur_next = cur_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                acc_next = acc_step;
                if (sh_reg == '0)
                begin
                    if (w_sub == '0)
                    begin
                        // common factor with the modulus: no inverse
                        res_next   = '0;
                        zero_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        r0_next    = r1_reg;
                        d0_next    = d1_reg;
                        t0_next    = t1_reg;
                        t1_next    = t0_reg ^ acc_step;
                        w_next     = w_sub;
                        cur_next   = d1_reg;
                        state_next = ST_NORM;
                    end
                end
                else
                begin
                    w_next  = {w_sub[N-1:0], 1'b0};
                    sh_next = sh_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        zero_reg <= zero_next;
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        cur_reg  <= cur_next;
        sh_reg   <= sh_next;
    end

    assign stat.idle    = (state_reg == ST_IDLE);
    assign stat.done    = (state_reg == ST_DONE);
    assign stat.zero_op = zero_reg;
    assign result       = res_reg;

endmodule

>>> hdl/gf2m_inverse_euclid.sv
// top level of the gf(2^m) inverter: stream ports, apb register, output register
//
// usage: an operand beat on s_axis (tdata bits FIELD_BITS-1:0) starts one inversion
// modulo the polynomial in the apb register at address 0 (bit FIELD_BITS forced set).
// the result beat on m_axis carries the inverse in tdata and, in tuser, a flag that
// is set when the operand was zero (inverse reported as 0). an operand sharing a
// factor with a reducible polynomial gives 0 with the flag clear.
// one operand is processed at a time: s_axis_tready is high while the engine idles.
// each euclid round runs quotient steps and then normalize steps in the bit-serial
// engine; a zero operand skips the euclid rounds and goes straight to its result.
// the next operand is taken the cycle after a result moves into the output register.
// a finished result sits in the output register; while m_axis_tready is low the
// engine accepts and works on the next operand and holds its result until the
// register frees up. reset loads x^10+x^3+1 and clears all valid state.
module gf2m_inverse_euclid #(
    parameter int FIELD_BITS = 10,
    localparam int DATA_W    = ((FIELD_BITS + 7) / 8) * 8,
    localparam int APB_W     = (FIELD_BITS + 1 > 32) ? 64 : 32,
    localparam int ADDR_W    = (APB_W == 64) ? 4 : 3
) (
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [FIELD_BITS-1:0] operand, rest zero
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [FIELD_BITS-1:0] inverse_value, rest zero
    output logic              m_axis_tuser,   // [0] zero_operand
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [FIELD_BITS:0]    poly;
    gf2i_pkg::core_stat_t   stat;
    logic [FIELD_BITS-1:0]  result;
    logic                   start;
    logic                   load;

    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0]  out_data_reg;
    logic                   out_zero_reg;

    assign pready = 1'b1;

    gf2i_cfg #(
        .FIELD_BITS (FIELD_BITS),
        .DATA_W     (APB_W),
        .ADDR_W     (ADDR_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .poly    (poly)
    );

    // input beat accepted only while the engine idles
    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid && stat.idle;

    gf2i_core #(
        .FIELD_BITS (FIELD_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (s_axis_tdata[FIELD_BITS-1:0]),
        .poly    (poly),
        .ack     (load),
        .stat    (stat),
        .result  (result)
    );

    // output register takes a result when empty or being drained
    assign load = stat.done && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
            out_zero_reg <= stat.zero_op;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_data_reg);
    assign m_axis_tuser  = out_zero_reg;

endmodule

>>> hdl/gf2i_checker.sv
// port-level checks of the gf(2^m) inverter and their bind
module gf2i_checker #(
    parameter int FIELD_BITS = 10,
    localparam int DATA_W    = ((FIELD_BITS + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [DATA_W-1:0] s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed under stall");

    // zero flag comes with a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero operand flag with nonzero value");

    // one operand at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second operand taken while busy");

    // zero operand with an empty output comes out flagged, straight through the done state
    a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[FIELD_BITS-1:0] == '0
            && !m_axis_tvalid |=> ##1 (m_axis_tvalid && m_axis_tuser))
        else $error("zero operand result missing");

endmodule

bind gf2m_inverse_euclid gf2i_checker #(.FIELD_BITS(FIELD_BITS)) u_checker (.*);

>>> tb/gf2m_inverse_checker.sv
// checker for the gf(2^10) inverter: tracks the polynomial, predicts each inverse, compares beats
`timescale 1ns / 100ps
module gf2m_inverse_checker #(
    parameter int                FIELD_W   = 10,
    parameter int                DATA_W    = 16,
    parameter int                APB_W     = 32,
    parameter int                ADDR_W    = 3,
    parameter logic [ADDR_W-1:0] POLY_ADDR = '0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [FIELD_W-1:0] operand, rest zero
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // [FIELD_W-1:0] inverse_value, rest zero
    input  logic              m_axis_tuser,   // [0] zero_operand
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    input  logic              pready,
    output int                error_count,
    output int                results_seen
);

    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic               zero_op;
    } inverse_beat_t;

    // polynomial as the block should hold it, top bit not yet forced
    logic [FIELD_W:0] poly_shadow;
    inverse_beat_t    expected_inverses[$];

    // index of the highest set bit, -1 for the zero polynomial
    function automatic int degree_of(logic [31:0] v);
        int d;
        d = -1;
        for (int i = 0; i < 32; i++)
            if (v[i])
                d = i;
        return d;
    endfunction

    // extended euclid over binary polynomials
    function automatic inverse_beat_t predict_inverse(logic [FIELD_W-1:0] op,
                                                      logic [FIELD_W:0] poly);
        logic [31:0]   modp;
        logic [31:0]   r_prev;
        logic [31:0]   r_cur;
        logic [31:0]   rem;
        logic [31:0]   quot;
        logic [31:0]   t_prev;
        logic [31:0]   t_cur;
        logic [31:0]   t_next;
        int            sh;
        int            d;
        inverse_beat_t res;
        modp = 32'(poly) | (32'd1 << FIELD_W);
        res  = '0;
        if (op == '0)
        begin
            res.zero_op = 1'b1;
            return res;
        end
        r_prev = modp;
        r_cur  = 32'(op);
        t_prev = '0;
        t_cur  = 32'd1;
        // stop once the remainder is one (inverse found) or zero (common factor)
        while (r_cur > 32'd1)
        begin
            // long division of r_prev by r_cur
            quot = '0;
            rem  = r_prev;
            for (sh = degree_of(rem) - degree_of(r_cur); sh >= 0;
                 sh = degree_of(rem) - degree_of(r_cur))
            begin
                quot ^= 32'd1 << sh;
                rem  ^= r_cur << sh;
            end
            // coefficient update: t_prev + quot * t_cur, reduced mod the polynomial
            t_next = t_prev;
            for (int b = 0; b <= FIELD_W; b++)
                if (quot[b])
                    t_next ^= t_cur << b;
            for (d = degree_of(t_next); d >= FIELD_W; d = degree_of(t_next))
                t_next ^= modp << (d - FIELD_W);
            r_prev = r_cur;
            r_cur  = rem;
            t_prev = t_cur;
            t_cur  = t_next;
        end
        if (r_cur == 32'd1)
            res.inverse = t_cur[FIELD_W-1:0];
        return res;
    endfunction

    // watch register writes, operand beats and result beats
    always @(posedge clk or negedge rst_n)
    begin : watch
        inverse_beat_t want;
        int            bad;
        if (!rst_n)
        begin
            poly_shadow <= gf2i_pkg::DEFAULT_POLY[FIELD_W:0];
            expected_inverses.delete();
            error_count  <= 0;
            results_seen <= 0;
        end
        else
        begin
            bad = 0;
            // polynomial write
            if (psel && penable && pwrite && pready && paddr == POLY_ADDR)
                poly_shadow <= pwdata[FIELD_W:0];
            // result beat against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_inverses.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    bad++;
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    if (m_axis_tdata[FIELD_W-1:0] !== want.inverse)
                    begin
                        $display("%0t: inverse_value mismatch, expected %h actual %h",
                                 $time, want.inverse, m_axis_tdata[FIELD_W-1:0]);
                        bad++;
                    end
                    if (m_axis_tuser !== want.zero_op)
                    begin
                        $display("%0t: zero_operand mismatch, expected %b actual %b",
                                 $time, want.zero_op, m_axis_tuser);
                        bad++;
                    end
                    if (m_axis_tdata[DATA_W-1:FIELD_W] !== '0)
                    begin
                        $display("%0t: tdata padding mismatch, expected 0 actual %h",
                                 $time, m_axis_tdata[DATA_W-1:FIELD_W]);
                        bad++;
                    end
                end
            end
            // operand beat, predicted with the polynomial in force
            if (s_axis_tvalid && s_axis_tready)
                expected_inverses.push_back(predict_inverse(s_axis_tdata[FIELD_W-1:0],
                                                            poly_shadow));
            error_count <= error_count + bad;
        end
    end

endmodule

>>> tb/gf2m_inverse_euclid_test.sv
// testbench top for the gf(2^10) inverter: clock, reset, operand and register stimulus, verdict
`timescale 1ns / 100ps
module gf2m_inverse_euclid_test;

    localparam int                FIELD_W       = 10;
    localparam int                DATA_W        = 16;
    localparam int                APB_W         = 32;
    localparam int                ADDR_W        = 3;
    localparam logic [ADDR_W-1:0] POLY_ADDR     = 3'd0;
    localparam int                RANDOM_PHASES = 8;
    localparam int                PHASE_ITEMS   = 100;
    localparam int                DRAIN_CYCLES  = 60;
    localparam int                CYCLE_LIMIT   = 400000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;    // [9:0] operand, rest zero
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;    // [9:0] inverse_value, rest zero
    logic              m_axis_tuser;    // [0] zero_operand
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    int operands_sent = 0;
    int cycle_count   = 0;
    int error_count;
    int results_seen;
    bit send_steady   = 1'b0;
    bit sink_steady   = 1'b0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    gf2m_inverse_euclid #(
        .FIELD_BITS(FIELD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    gf2m_inverse_checker #(
        .FIELD_W  (FIELD_W),
        .DATA_W   (DATA_W),
        .APB_W    (APB_W),
        .ADDR_W   (ADDR_W),
        .POLY_ADDR(POLY_ADDR)
    ) inverse_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .error_count  (error_count),
        .results_seen (results_seen)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one operand beat after a random gap, valid stays high across back-to-back beats
    task automatic send_operand(input logic [FIELD_W-1:0] op);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(op);
        do
            @(posedge clk);
        while (!s_axis_tready);
        operands_sent++;
    endtask

    // stop sending and wait for every outstanding inverse
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen != operands_sent);
    endtask

    // apb write of the polynomial register, setup then access
    task automatic write_poly(input logic [APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POLY_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random stall before each beat, with stretches of no stall
    initial
    begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // operand and register stimulus, then verdict
    initial
    begin : stimulus
        logic [FIELD_W-1:0] op;
        int                 pick;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset polynomial: zero, one, all ones, single bits, alternating bits, low byte set
        send_operand(10'h000);
        send_operand(10'h001);
        send_operand(10'h3ff);
        send_operand(10'h200);
        send_operand(10'h002);
        send_operand(10'h155);
        send_operand(10'h2aa);
        send_operand(10'h0ff);
        drain_results();

        // lowest polynomial x^10, operands sharing the factor x give 0
        write_poly(32'h0000_0400);
        send_operand(10'h002);
        send_operand(10'h003);
        send_operand(10'h3ff);
        drain_results();

        // highest polynomial
        write_poly(32'h0000_07ff);
        send_operand(10'h001);
        send_operand(10'h3ff);
        send_operand(10'h0f0);
        drain_results();

        // reducible x^10+1, operands with a common factor
        write_poly(32'h0000_0401);
        send_operand(10'h003);
        send_operand(10'h021);
        drain_results();

        // top bit clear and junk above the register width
        write_poly(32'hffff_f809);
        send_operand(10'h000);
        send_operand(10'h001);
        send_operand(10'h123);
        drain_results();

        // random phases, each under a fresh polynomial
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: write_poly(32'h0000_0409);
                1: write_poly(32'h0000_0481);
                2: write_poly($urandom());
                default: write_poly(APB_W'($urandom_range(1024, 2047)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 15);
                case (pick)
                    0: op = '0;
                    1: op = 10'h001;
                    2: op = 10'h001 << $urandom_range(0, FIELD_W - 1);
                    3: op = 10'h3ff;
                    default: op = FIELD_W'($urandom_range(0, 1023));
                endcase
                send_operand(op);
            end
            drain_results();
        end

        // let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
